### design/brf_pkg.sv
// Shared constants, command codes and control types for the byte ring FIFO.
package brf_pkg;

    // Store geometry. ALIGN must be a power of two.
    localparam int DEPTH  = 1024;
    localparam int ALIGN  = 4;

    // Field widths.
    localparam int IDX_W  = 10;
    localparam int SIZE_W = 11;
    localparam int DATA_W = 8;
    localparam int CMD_W  = 4;
    localparam int BLEN_W = 16;
    localparam int FILL_W = 2;

    localparam logic [SIZE_W-1:0] DEPTH_SZ   = SIZE_W'(DEPTH);
    localparam logic [SIZE_W-1:0] ALIGN_MASK = SIZE_W'(ALIGN - 1);
    localparam logic [SIZE_W-1:0] RESET_SIZE = DEPTH_SZ & ~ALIGN_MASK;

    // Byte-level commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT       = 4'd0,
        CMD_FORCE_PUT = 4'd1,
        CMD_OVERLAY   = 4'd2,
        CMD_IN_PLACE  = 4'd3,
        CMD_GET       = 4'd4,
        CMD_PEEK      = 4'd5,
        CMD_CLEAR     = 4'd6,
        CMD_SET_READ  = 4'd7,
        CMD_SET_WRITE = 4'd8,
        CMD_LOCATE    = 4'd9
    } t_cmd;

    // Fill state codes.
    localparam logic [FILL_W-1:0] FILL_EMPTY   = 2'd0;
    localparam logic [FILL_W-1:0] FILL_FULL    = 2'd1;
    localparam logic [FILL_W-1:0] FILL_PARTIAL = 2'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;    // capture the input transaction
        logic exec;    // apply the command, write store, issue read
        logic finish;  // capture read byte and final level
        logic cfg_wr;  // write size_in_use
    } t_dp_cmd;

endpackage

### design/brf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/brf_ctrl.sv
// Controller: sequences one transaction through load, execute, read and result.
module brf_ctrl
    import brf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;
    logic   r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_READ;
            S_READ: n_state = S_RESP;
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= (n_state == S_IDLE);
            r_out_valid <= (n_state == S_RESP);
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_cfg_ready = r_in_ready;
    assign o_out_valid = r_out_valid;

    // Datapath commands
    always_comb begin
        o_cmd.load   = i_in_valid & r_in_ready;
        o_cmd.exec   = (r_state == S_EXEC);
        o_cmd.finish = (r_state == S_READ);
        o_cmd.cfg_wr = i_cfg_valid & r_in_ready;
    end

endmodule

### design/brf_dp.sv
// Datapath: pointers, size register, command decode, byte store and result registers.
module brf_dp
    import brf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [CMD_W-1:0]  i_cmd_code,
    input  logic [DATA_W-1:0] i_data_in,
    input  logic [SIZE_W-1:0] i_offset,
    input  logic [IDX_W-1:0]  i_set_index,
    input  logic              i_set_mirror,
    input  logic [BLEN_W-1:0] i_burst_length,
    input  logic [SIZE_W-1:0] i_cfg_data,
    output logic [DATA_W-1:0] o_data_out,
    output logic              o_accepted,
    output logic [FILL_W-1:0] o_fill_state,
    output logic [SIZE_W-1:0] o_level,
    output logic [IDX_W-1:0]  o_read_pos,
    output logic              o_read_wrap,
    output logic [IDX_W-1:0]  o_write_pos,
    output logic              o_write_wrap,
    output logic [IDX_W-1:0]  o_located_index,
    output logic              o_located_mirror
);

    // Captured transaction
    t_cmd              r_cmd;
    logic [DATA_W-1:0] r_data_in;
    logic [SIZE_W-1:0] r_offset;
    logic [IDX_W-1:0]  r_set_index;
    logic              r_set_mirror;
    logic [BLEN_W-1:0] r_burst_length;

    // Ring state
    logic [SIZE_W-1:0] r_size;
    logic [IDX_W-1:0]  r_rp, n_rp;
    logic              r_rm, n_rm;
    logic [IDX_W-1:0]  r_wp, n_wp;
    logic              r_wm, n_wm;

    // Results
    logic [DATA_W-1:0] r_data_out;
    logic              r_accepted, n_accepted;
    logic [FILL_W-1:0] r_fill;
    logic [SIZE_W-1:0] r_level;
    logic [IDX_W-1:0]  r_loc_i, n_loc_i;
    logic              r_loc_m, n_loc_m;
    logic              r_rd_en, n_rd_en;

    // Store access
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic [SIZE_W-1:0] lvl;
    logic [SIZE_W-1:0] w_inc, r_inc;
    logic [IDX_W-1:0]  w_adv_p, r_adv_p;
    logic              w_adv_m, r_adv_m;
    logic [IDX_W-1:0]  wrap_base;
    logic [SIZE_W:0]   wrap_sum, wrap_res;
    logic [IDX_W-1:0]  wrap_addr;
    logic [SIZE_W:0]   loc_far;
    logic              blen_ok;
    logic              idx_ok;
    logic [SIZE_W-1:0] cfg_sat, cfg_size;

    // Level from current pointers: before the command in execute, after it in finish
    always_comb begin
        if (r_rp == r_wp) begin
            lvl = (r_rm == r_wm) ? '0 : r_size;
        end else if (r_wp > r_rp) begin
            lvl = {1'b0, r_wp} - {1'b0, r_rp};
        end else begin
            lvl = r_size - {1'b0, r_rp} + {1'b0, r_wp};
        end
    end

    // Advance both pointers, wrapping at size_in_use
    always_comb begin
        w_inc = {1'b0, r_wp} + SIZE_W'(1);
        r_inc = {1'b0, r_rp} + SIZE_W'(1);
        if (w_inc >= r_size) begin
            w_adv_p = '0;
            w_adv_m = ~r_wm;
        end else begin
            w_adv_p = w_inc[IDX_W-1:0];
            w_adv_m = r_wm;
        end
        if (r_inc >= r_size) begin
            r_adv_p = '0;
            r_adv_m = ~r_rm;
        end else begin
            r_adv_p = r_inc[IDX_W-1:0];
            r_adv_m = r_rm;
        end
    end

    // Offset address, wrapped once modulo size_in_use
    always_comb begin
        wrap_base = (r_cmd == CMD_PEEK) ? r_rp : r_wp;
        wrap_sum  = {2'b0, wrap_base} + {1'b0, r_offset};
        wrap_res  = (wrap_sum >= {1'b0, r_size}) ? wrap_sum - {1'b0, r_size} : wrap_sum;
        wrap_addr = wrap_res[IDX_W-1:0];
    end

    assign loc_far = {1'b0, r_size} + {2'b0, r_wp} - {1'b0, r_offset};
    assign blen_ok = (r_burst_length <= {{(BLEN_W-SIZE_W){1'b0}}, r_size});
    assign idx_ok  = ({1'b0, r_set_index} < r_size);

    // Command decode
    always_comb begin
        n_rp       = r_rp;
        n_rm       = r_rm;
        n_wp       = r_wp;
        n_wm       = r_wm;
        n_accepted = 1'b0;
        n_rd_en    = 1'b0;
        n_loc_i    = '0;
        n_loc_m    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_wp;
        mem_raddr  = r_rp;
        case (r_cmd)
            CMD_PUT: begin
                if (lvl < r_size) begin
                    mem_we     = 1'b1;
                    n_wp       = w_adv_p;
                    n_wm       = w_adv_m;
                    n_accepted = 1'b1;
                end
            end
            CMD_FORCE_PUT: begin
                mem_we     = 1'b1;
                n_wp       = w_adv_p;
                n_wm       = w_adv_m;
                n_accepted = 1'b1;
                if (lvl == r_size) begin
                    n_rp = r_adv_p;
                    n_rm = r_adv_m;
                end
            end
            CMD_OVERLAY: begin
                if (blen_ok) begin
                    mem_we     = 1'b1;
                    n_wp       = w_adv_p;
                    n_wm       = w_adv_m;
                    n_accepted = 1'b1;
                end
            end
            CMD_IN_PLACE: begin
                mem_waddr = wrap_addr;
                if (blen_ok && (r_offset < r_size)) begin
                    mem_we     = 1'b1;
                    n_accepted = 1'b1;
                end
            end
            CMD_GET: begin
                if (lvl != '0) begin
                    n_rd_en    = 1'b1;
                    n_rp       = r_adv_p;
                    n_rm       = r_adv_m;
                    n_accepted = 1'b1;
                end
            end
            CMD_PEEK: begin
                mem_raddr = wrap_addr;
                if (r_offset < lvl) begin
                    n_rd_en    = 1'b1;
                    n_accepted = 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_rp       = '0;
                n_rm       = 1'b0;
                n_wp       = '0;
                n_wm       = 1'b0;
                n_accepted = 1'b1;
            end
            CMD_SET_READ: begin
                if (idx_ok) begin
                    n_rp       = r_set_index;
                    n_rm       = r_set_mirror;
                    n_accepted = 1'b1;
                end
            end
            CMD_SET_WRITE: begin
                if (idx_ok) begin
                    n_wp       = r_set_index;
                    n_wm       = r_set_mirror;
                    n_accepted = 1'b1;
                end
            end
            CMD_LOCATE: begin
                if (r_offset <= {1'b0, r_wp}) begin
                    n_loc_i    = r_wp - r_offset[IDX_W-1:0];
                    n_loc_m    = r_wm;
                    n_accepted = 1'b1;
                end else if (r_offset <= r_size) begin
                    n_loc_i    = loc_far[IDX_W-1:0];
                    n_loc_m    = ~r_wm;
                    n_accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Size write: saturate to the store depth, round down to the alignment
    always_comb begin
        cfg_sat  = (i_cfg_data > DEPTH_SZ) ? DEPTH_SZ : i_cfg_data;
        cfg_size = cfg_sat & ~ALIGN_MASK;
    end

    // Ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= RESET_SIZE;
            r_rp   <= '0;
            r_rm   <= 1'b0;
            r_wp   <= '0;
            r_wm   <= 1'b0;
        end else if (i_cmd.cfg_wr && (cfg_size != '0)) begin
            r_size <= cfg_size;
            r_rp   <= '0;
            r_rm   <= 1'b0;
            r_wp   <= '0;
            r_wm   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_rp <= n_rp;
            r_rm <= n_rm;
            r_wp <= n_wp;
            r_wm <= n_wm;
        end
    end

    // Capture the transaction and the results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd          <= t_cmd'(i_cmd_code);
            r_data_in      <= i_data_in;
            r_offset       <= i_offset;
            r_set_index    <= i_set_index;
            r_set_mirror   <= i_set_mirror;
            r_burst_length <= i_burst_length;
        end
        if (i_cmd.exec) begin
            r_accepted <= n_accepted;
            r_rd_en    <= n_rd_en;
            r_loc_i    <= n_loc_i;
            r_loc_m    <= n_loc_m;
        end
        if (i_cmd.finish) begin
            r_data_out <= r_rd_en ? mem_rdata : '0;
            r_level    <= lvl;
            if (lvl == '0) begin
                r_fill <= FILL_EMPTY;
            end else if (lvl == r_size) begin
                r_fill <= FILL_FULL;
            end else begin
                r_fill <= FILL_PARTIAL;
            end
        end
    end

    brf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we & i_cmd.exec),
        .i_waddr (mem_waddr),
        .i_wdata (r_data_in),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_data_out       = r_data_out;
    assign o_accepted       = r_accepted;
    assign o_fill_state     = r_fill;
    assign o_level          = r_level;
    assign o_read_pos       = r_rp;
    assign o_read_wrap      = r_rm;
    assign o_write_pos      = r_wp;
    assign o_write_wrap     = r_wm;
    assign o_located_index  = r_loc_i;
    assign o_located_mirror = r_loc_m;

endmodule

### design/byte_ring_fifo_mirror.sv
// Top level of the byte ring FIFO with mirror-bit pointers.
//
//   channel   direction  handshake                    payload
//   input     in         i_in_valid / o_in_ready      i_cmd .. i_burst_length
//   result    out        o_out_valid / i_out_ready    o_data_out .. o_located_mirror
//   config    in         i_cfg_valid / o_cfg_ready    i_cfg_data (size_in_use)
//
// A transaction accepted at one edge executes in the next cycle, reads the byte
// store in the cycle after, and o_out_valid is high from the result state on until
// i_out_ready takes the result; the next transaction can be taken in the cycle after
// the result is taken, not before. The registered store read is why a read state
// lies between execute and result. Reset is synchronous and needs no clearing pass
// over the store; the ready outputs rise in the cycle after release.
module byte_ring_fifo_mirror
    import brf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [DATA_W-1:0] i_data_in,
    input  logic [SIZE_W-1:0] i_offset,
    input  logic [IDX_W-1:0]  i_set_index,
    input  logic              i_set_mirror,
    input  logic [BLEN_W-1:0] i_burst_length,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_data_out,
    output logic              o_accepted,
    output logic [FILL_W-1:0] o_fill_state,
    output logic [SIZE_W-1:0] o_level,
    output logic [IDX_W-1:0]  o_read_pos,
    output logic              o_read_wrap,
    output logic [IDX_W-1:0]  o_write_pos,
    output logic              o_write_wrap,
    output logic [IDX_W-1:0]  o_located_index,
    output logic              o_located_mirror,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    t_dp_cmd dp_cmd;

    brf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (dp_cmd)
    );

    brf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_cmd_code       (i_cmd),
        .i_data_in        (i_data_in),
        .i_offset         (i_offset),
        .i_set_index      (i_set_index),
        .i_set_mirror     (i_set_mirror),
        .i_burst_length   (i_burst_length),
        .i_cfg_data       (i_cfg_data),
        .o_data_out       (o_data_out),
        .o_accepted       (o_accepted),
        .o_fill_state     (o_fill_state),
        .o_level          (o_level),
        .o_read_pos       (o_read_pos),
        .o_read_wrap      (o_read_wrap),
        .o_write_pos      (o_write_pos),
        .o_write_wrap     (o_write_wrap),
        .o_located_index  (o_located_index),
        .o_located_mirror (o_located_mirror)
    );

endmodule
